>>> rtl/core/lcg_ranged_random_macros.svh
// Assertion macros for the ranged random generator checker
`ifndef LCG_RANGED_RANDOM_MACROS_SVH
`define LCG_RANGED_RANDOM_MACROS_SVH

// Checked only out of reset
`define LCGR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define LCGR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/lcgr_pkg.sv
// Types and constants of the ranged random generator
package lcgr_pkg;

  localparam logic [31:0] LcgMul   = 32'd214013;
  localparam logic [31:0] LcgAdd   = 32'd2531011;
  localparam logic [31:0] ScaleDiv = 32'd65535;

  // Divider steps: integer draws shift out 32 dividend bits
  localparam logic [5:0] IntSteps   = 6'd32;

  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_INT    = 2'd1,
    OP_SCALED = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_e;

  // What the back part has to do with a queued request
  typedef enum logic [2:0] {
    K_ZERO,
    K_ERR,
    K_FULL,
    K_INT,
    K_SCALED
  } kind_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_EST,
    B_FIX,
    B_DIV,
    B_FIN
  } back_state_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] lo;
    logic [31:0] opa;   // tempered word, or state[31:16] for scaled draws
    logic [31:0] opb;   // modulus, or |high - low| for scaled draws
    logic        neg;   // high below low on a scaled draw
  } entry_t;

endpackage

>>> rtl/core/lcgr_ifs.sv
// Request and result channel interfaces
interface lcgr_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [31:0]        seed_value;
  logic signed [31:0] low_bound;
  logic signed [31:0] high_bound;

  modport source (output valid, opcode, seed_value, low_bound, high_bound, input ready);
  modport sink   (input valid, opcode, seed_value, low_bound, high_bound, output ready);
endinterface

interface lcgr_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] draw_value;
  logic               range_error;

  modport source (output valid, draw_value, range_error, input ready);
  modport sink   (input valid, draw_value, range_error, output ready);
endinterface

>>> rtl/core/lcgr_front.sv
// Front part: generator state, request accept and classification
module lcgr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  lcgr_req_if.sink            req_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output lcgr_pkg::entry_t    push_entry_o
);

  logic [31:0] state_q, state_d;
  logic [31:0] state_next;
  logic [31:0] tempered;
  logic [32:0] diff;
  logic        accept;
  lcgr_pkg::opcode_e op;

  assign op         = lcgr_pkg::opcode_e'(req_i.opcode);
  assign accept     = req_i.valid && push_ready_i;
  assign req_i.ready   = push_ready_i;
  assign push_valid_o  = req_i.valid;

  assign state_next = state_q * lcgr_pkg::LcgMul + lcgr_pkg::LcgAdd;
  assign tempered   = state_next ^ (state_next >> 15);
  assign diff       = {req_i.high_bound[31], req_i.high_bound}
                    - {req_i.low_bound[31], req_i.low_bound};

  always_comb begin
    state_d = state_q;
    push_entry_o.kind = lcgr_pkg::K_ZERO;
    push_entry_o.lo   = req_i.low_bound;
    push_entry_o.opa  = tempered;
    push_entry_o.opb  = diff[31:0] + 32'd1;
    push_entry_o.neg  = 1'b0;
    unique case (op)
      lcgr_pkg::OP_RESEED: begin
        state_d = req_i.seed_value;
      end
      lcgr_pkg::OP_INT: begin
        state_d = state_next;
        // Inverted range, then the full 2^32 span, then an ordinary remainder
        priority if (diff[32]) begin
          push_entry_o.kind = lcgr_pkg::K_ERR;
        end else if (diff == 33'h0_FFFF_FFFF) begin
          push_entry_o.kind = lcgr_pkg::K_FULL;
        end else begin
          push_entry_o.kind = lcgr_pkg::K_INT;
        end
      end
      lcgr_pkg::OP_SCALED: begin
        state_d = state_next;
        push_entry_o.kind = lcgr_pkg::K_SCALED;
        push_entry_o.opa  = {16'd0, state_next[31:16]};
        push_entry_o.neg  = diff[32];
        push_entry_o.opb  = diff[32] ? 32'(-diff) : diff[31:0];
      end
      lcgr_pkg::OP_UNUSED: begin
        state_d = state_q;
      end
      default: begin
        state_d = state_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= 32'd0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/lcgr_queue.sv
// Two-entry queue between the front and back parts
module lcgr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  lcgr_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output lcgr_pkg::entry_t pop_entry_o
);

  lcgr_pkg::entry_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/core/lcgr_back.sv
// Back part: multiplier, scaled-draw reduction, radix-2 divider and result register
module lcgr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  lcgr_pkg::entry_t pop_entry_i,
  lcgr_rsp_if.source       rsp_o
);

  lcgr_pkg::back_state_e state_q, state_d;

  lcgr_pkg::kind_e kind_q;
  logic [31:0] lo_q;
  logic [15:0] frac_q;
  logic [31:0] mag_q;
  logic        neg_q;
  logic [47:0] dvd_q;     // dividend, shifted out as quotient bits shift in
  logic [31:0] rem_q;
  logic [31:0] div_q;
  logic [5:0]  cnt_q;

  logic        out_valid_q;
  logic [31:0] out_value_q;
  logic        out_err_q;

  logic        pop;
  logic        out_load;
  logic [47:0] prod;
  logic [32:0] rem_sh;
  logic        ge;
  logic [47:0] est;
  logic [47:0] resid;
  logic        fix;
  logic [31:0] quot;
  logic [31:0] result;
  logic        result_err;

  assign pop_ready_o = (state_q == lcgr_pkg::B_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign out_load    = (state_q == lcgr_pkg::B_FIN) && (!out_valid_q || rsp_o.ready);

  assign prod   = {32'd0, frac_q} * {16'd0, mag_q};
  assign rem_sh = {rem_q, dvd_q[47]};
  assign ge     = rem_sh >= {1'b0, div_q};
  assign quot   = dvd_q[31:0];

  // Divide by 65535: estimate from the sum of 16-bit shifts, then one correction
  assign est   = dvd_q + {16'd0, dvd_q[47:16]} + {32'd0, dvd_q[47:32]};
  assign resid = dvd_q - {rem_q, 16'd0} + {16'd0, rem_q};
  assign fix   = resid >= {16'd0, lcgr_pkg::ScaleDiv};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcgr_pkg::B_IDLE: begin
        if (pop) begin
          unique case (pop_entry_i.kind)
            lcgr_pkg::K_INT:    state_d = lcgr_pkg::B_DIV;
            lcgr_pkg::K_SCALED: state_d = lcgr_pkg::B_MUL;
            default:            state_d = lcgr_pkg::B_FIN;
          endcase
        end
      end
      lcgr_pkg::B_MUL: state_d = lcgr_pkg::B_EST;
      lcgr_pkg::B_EST: state_d = lcgr_pkg::B_FIX;
      lcgr_pkg::B_FIX: state_d = lcgr_pkg::B_FIN;
      lcgr_pkg::B_DIV: begin
        if (cnt_q == 6'd1) begin
          state_d = lcgr_pkg::B_FIN;
        end
      end
      lcgr_pkg::B_FIN: begin
        if (out_load) begin
          state_d = lcgr_pkg::B_IDLE;
        end
      end
      default: state_d = lcgr_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    result_err = 1'b0;
    unique case (kind_q)
      lcgr_pkg::K_ZERO: result = 32'd0;
      lcgr_pkg::K_ERR: begin
        result     = lo_q;
        result_err = 1'b1;
      end
      lcgr_pkg::K_FULL,
      lcgr_pkg::K_INT:    result = lo_q + rem_q;
      lcgr_pkg::K_SCALED: result = lo_q + (neg_q ? -quot : quot);
      default:            result = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcgr_pkg::B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      kind_q <= pop_entry_i.kind;
      lo_q   <= pop_entry_i.lo;
      frac_q <= pop_entry_i.opa[15:0];
      mag_q  <= pop_entry_i.opb;
      neg_q  <= pop_entry_i.neg;
      rem_q  <= (pop_entry_i.kind == lcgr_pkg::K_FULL) ? pop_entry_i.opa : 32'd0;
      dvd_q  <= {pop_entry_i.opa, 16'd0};
      div_q  <= pop_entry_i.opb;
      cnt_q  <= lcgr_pkg::IntSteps;
    end else if (state_q == lcgr_pkg::B_MUL) begin
      dvd_q <= prod;
    end else if (state_q == lcgr_pkg::B_EST) begin
      // Hold the quotient estimate in the remainder register
      rem_q <= est[47:16];
    end else if (state_q == lcgr_pkg::B_FIX) begin
      dvd_q <= {16'd0, rem_q + {31'd0, fix}};
    end else if (state_q == lcgr_pkg::B_DIV) begin
      // Shift in one dividend bit, subtract when it fits
      dvd_q <= {dvd_q[46:0], ge};
      rem_q <= ge ? 32'(rem_sh - {1'b0, div_q}) : rem_sh[31:0];
      cnt_q <= cnt_q - 6'd1;
    end
    if (out_load) begin
      out_value_q <= result;
      out_err_q   <= result_err;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.draw_value  = out_value_q;
  assign rsp_o.range_error = out_err_q;

endmodule

>>> rtl/core/lcg_ranged_random.sv
// Request to result: the two-entry queue, then the back part, which goes straight to its result
// stage for reseed, unused opcode, inverted integer range and full-span draws, runs the 32-step
// radix-2 divider for integer draws and the multiply, estimate and fix states for scaled draws.
// The back part takes a new request only when idle; the two-entry queue takes requests while it runs.
// Reset (rst_ni low, asynchronous) zeroes the state and empties queue and result register.
// Top level of the ranged random generator
module lcg_ranged_random (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcgr_req_if.sink    req_i,
  lcgr_rsp_if.source  rsp_o
);

  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  lcgr_pkg::entry_t push_entry, pop_entry;

  lcgr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  lcgr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  lcgr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .rsp_o       (rsp_o)
  );

endmodule

>>> rtl/core/lcgr_checker.sv
// Port-level checks of the ranged random generator, bound to the top level
`include "lcg_ranged_random_macros.svh"

module lcgr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] draw_value_i,
  input logic        range_error_i
);

  logic [2:0] pending_q;
  logic       req_acc, rsp_acc;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  // Track requests taken whose result is not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else begin
      pending_q <= pending_q + {2'd0, req_acc} - {2'd0, rsp_acc};
    end
  end

  `LCGR_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(draw_value_i) && $stable(range_error_i), "stalled result changed")
  `LCGR_ASSERT(a_no_spurious, rsp_valid_i |-> pending_q != 3'd0, "result without a pending request")
  `LCGR_ASSERT(a_pending_bound, pending_q <= 3'd4, "more requests in flight than storage")
  `LCGR_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !rsp_valid_i, "result valid during reset")

endmodule

bind lcg_ranged_random lcgr_checker u_lcgr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .draw_value_i  (rsp_o.draw_value),
  .range_error_i (rsp_o.range_error)
);

>>> tb/sv/tb_lcg_ranged_random.sv
// Self-checking testbench for the ranged random generator: directed and random requests
`timescale 1ns / 1ps

module tb_lcg_ranged_random;

  localparam longint      DrawDivisor   = 64'sd65535;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldAtResult  = 200;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned RandomReqs    = 800;

  typedef struct {
    lcgr_pkg::opcode_e op;
    logic [31:0]       seed;
    logic [31:0]       lo;
    logic [31:0]       hi;
    int unsigned       gap;
    bit                drain;
  } draw_req_t;

  typedef struct {
    logic [31:0] value;
    logic        err;
  } draw_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  lcgr_req_if req ();
  lcgr_rsp_if rsp ();

  lcg_ranged_random dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  draw_req_t   req_queue[$];
  draw_t       draws_due[$];
  logic [31:0] gen_word = '0;
  int unsigned accepted_n;
  int unsigned received_n;
  int unsigned fail_count = 0;

  // Advance the generator and work out the result one request yields
  function automatic draw_t predict_draw(input logic [1:0] op, input logic [31:0] seed,
                                         input logic signed [31:0] lo,
                                         input logic signed [31:0] hi);
    draw_t       d;
    longint      lo_w;
    longint      hi_w;
    longint      span;
    longint      part;
    logic [31:0] tempered;
    d.value = '0;
    d.err   = 1'b0;
    lo_w    = lo;
    hi_w    = hi;
    case (lcgr_pkg::opcode_e'(op))
      lcgr_pkg::OP_RESEED: gen_word = seed;
      lcgr_pkg::OP_INT: begin
        gen_word = gen_word * lcgr_pkg::LcgMul + lcgr_pkg::LcgAdd;
        if (hi_w < lo_w) begin
          d.value = lo;
          d.err   = 1'b1;
        end else begin
          tempered = gen_word ^ (gen_word >> 15);
          span     = hi_w - lo_w + 1;
          if (span > 64'sh0_FFFF_FFFF) part = longint'({32'b0, tempered});
          else part = longint'({32'b0, tempered}) % span;
          d.value = 32'(lo_w + part);
        end
      end
      lcgr_pkg::OP_SCALED: begin
        gen_word = gen_word * lcgr_pkg::LcgMul + lcgr_pkg::LcgAdd;
        span     = hi_w - lo_w;
        part     = (longint'({48'b0, gen_word[31:16]}) * span) / DrawDivisor;
        d.value  = 32'(lo_w + part);
      end
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] edge_value(input int unsigned k);
    case (k)
      0: return 32'h8000_0000;
      1: return 32'h8000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4: return 32'h0000_0001;
      5: return 32'h7FFF_FFFE;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
    case ($urandom_range(5, 0))
      0: begin
        lo = $urandom;
        hi = $urandom;
      end
      1: begin
        lo = $urandom;
        hi = lo + $urandom_range(1000, 0);
      end
      2: begin
        lo = 32'($urandom_range(32'h0010_0000, 0)) - 32'h0008_0000;
        hi = 32'($urandom_range(32'h0010_0000, 0)) - 32'h0008_0000;
      end
      3: begin
        lo = edge_value($urandom_range(6, 0));
        hi = edge_value($urandom_range(6, 0));
      end
      4: begin
        lo = $urandom;
        hi = lo + ((32'd1 << $urandom_range(31, 0)) - 32'd1);
      end
      default: begin
        // Q16.16 bounds within +/-100
        lo = 32'($urandom_range(32'h00C8_0000, 0)) - 32'h0064_0000;
        hi = 32'($urandom_range(32'h00C8_0000, 0)) - 32'h0064_0000;
      end
    endcase
  endtask

  task automatic add_req(input lcgr_pkg::opcode_e op, input logic [31:0] seed,
                         input logic [31:0] lo, input logic [31:0] hi,
                         input bit idle, input bit drain);
    draw_req_t r;
    r.op    = op;
    r.seed  = seed;
    r.lo    = lo;
    r.hi    = hi;
    r.gap   = idle ? $urandom_range(19, 0) : 0;
    r.drain = drain;
    req_queue.push_back(r);
  endtask

  // Request driver
  draw_req_t   next_req;
  bit          have_next;
  bit          took;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid      <= 1'b0;
      req.opcode     <= lcgr_pkg::OP_RESEED;
      req.seed_value <= '0;
      req.low_bound  <= '0;
      req.high_bound <= '0;
      accepted_n     <= 0;
      have_next      = 1'b0;
      gap_left       = 0;
      gen_word       = '0;
    end else begin
      took = req.valid && req.ready;
      if (took) begin
        draws_due.push_back(predict_draw(req.opcode, req.seed_value,
                                         req.low_bound, req.high_bound));
        accepted_n <= accepted_n + 1;
      end
      if (!req.valid || req.ready) begin
        if (!have_next && req_queue.size() != 0) begin
          next_req  = req_queue.pop_front();
          have_next = 1'b1;
          gap_left  = next_req.gap;
        end
        if (have_next && gap_left == 0 &&
            !(next_req.drain && (took || accepted_n != received_n))) begin
          req.valid      <= 1'b1;
          req.opcode     <= next_req.op;
          req.seed_value <= next_req.seed;
          req.low_bound  <= next_req.lo;
          req.high_bound <= next_req.hi;
          have_next      = 1'b0;
        end else begin
          req.valid <= 1'b0;
          if (have_next && gap_left != 0) gap_left--;
        end
      end
    end
  end

  // Result monitor and checker
  draw_t       due;
  int unsigned stall_left;
  int unsigned hold_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready  <= 1'b0;
      received_n <= 0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (draws_due.size() == 0) begin
          $error("unexpected result: draw_value %0d range_error %0b",
                 $signed(rsp.draw_value), rsp.range_error);
          fail_count++;
        end else begin
          due = draws_due.pop_front();
          if (rsp.draw_value !== due.value) begin
            $error("draw_value: expected %0d, got %0d",
                   $signed(due.value), $signed(rsp.draw_value));
            fail_count++;
          end
          if (rsp.range_error !== due.err) begin
            $error("range_error: expected %0b, got %0b", due.err, rsp.range_error);
            fail_count++;
          end
        end
        received_n <= received_n + 1;
        stall_left = ((received_n / 90) % 3 != 0) ? $urandom_range(19, 0) : 0;
        // Hold off for a long stretch once, so the queue fills and the input stalls
        if (received_n == HoldAtResult) hold_left = HoldCycles;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      if (hold_left != 0) hold_left--;
      rsp.ready <= (stall_left == 0 && hold_left == 0);
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("lcg_ranged_random regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0]       lo;
    logic [31:0]       hi;
    int unsigned       pick;
    bit                idle;
    lcgr_pkg::opcode_e op;

    #1 rst_ni = 1'b0;

    // Directed: draw from reset state, extremes, inverted and full spans, every opcode
    add_req(lcgr_pkg::OP_INT,    '0, 32'd0, 32'd9, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_RESEED, 32'hFFFF_FFFF, $urandom, $urandom, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_INT,    '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_INT,    '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_INT,    '0, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_INT,    '0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_INT,    '0, 32'd5, 32'd4, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_INT,    '0, 32'hFFFF_FF9C, 32'd100, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_INT,    '0, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_SCALED, '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_SCALED, '0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_SCALED, '0, 32'h0001_8000, 32'h0001_8000, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_SCALED, '0, 32'hFFFF_0000, 32'h0003_0000, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_SCALED, '0, 32'h0003_0000, 32'hFFFF_0000, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_UNUSED, $urandom, $urandom, $urandom, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_INT,    '0, 32'd1, 32'd1000, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_RESEED, 32'h0000_0000, 32'd0, 32'd0, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_SCALED, '0, 32'd0, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_RESEED, 32'h8000_0001, 32'd0, 32'd0, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_INT,    '0, 32'h8000_0000, 32'h8000_0001, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_req(lcgr_pkg::OP_INT,    '0, 32'd0, 32'd0, 1'b0, 1'b0);

    for (int unsigned i = 0; i < RandomReqs; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 6) op = lcgr_pkg::OP_RESEED;
      else if (pick < 50) op = lcgr_pkg::OP_INT;
      else if (pick < 94) op = lcgr_pkg::OP_SCALED;
      else op = lcgr_pkg::OP_UNUSED;
      pick_bounds(lo, hi);
      // Keep the sender busy around the long receiver hold and in some other stretches
      idle = !((i >= 150 && i < 300) || (i / 120) % 3 == 2);
      add_req(op, $urandom, lo, hi, idle, i == 0 || i == 400 || i == 650);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_queue.size() != 0 || have_next || req.valid || accepted_n != received_n)
      @(negedge clk_i);
    repeat (60) @(negedge clk_i);

    if (draws_due.size() != 0) begin
      $error("%0d expected results never arrived", draws_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("lcg_ranged_random regression: pass");
    end else begin
      $display("lcg_ranged_random regression: fail");
    end
    $finish;
  end

endmodule
